### hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg: shared codes of the first-fit page allocator
// Request kinds and response status codes used on the stream ports.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int STATUS_W = 2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

endpackage

### hdl/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator: first-fit contiguous page allocator
// A request word either allocates a run of pages from the lowest free block
// that is long enough, or frees a run and merges it with its free neighbors.
// - The request stream carries the kind (allocate or free) in req_tuser and
//   the count and base page in req_tdata. Each request gives one response
//   word: status in rsp_tuser, page index and remaining free total in rsp_tdata.
// - One request is handled at a time; req_tready is low while it is worked on.
//   A single page store port, walked one address a cycle, sets the cost: an
//   allocate runs a first-fit search and then an update; a free checks the
//   run page by page, marks it free, then merges it with the free blocks
//   above and below.
// - After reset, and after every csr_we write of the managed size, a clearing
//   pass rebuilds the pool; no request is taken meanwhile.
// - The response sits in an output register while rsp_tready is low. The next
//   request is still taken and worked on, but its response waits in the
//   sequencer until the register drains, and no further request is taken.
// ----------------------------------------------------------------------------
module first_fit_page_allocator #(
   parameter int PAGES = 256,
   localparam int IDX_W = $clog2(PAGES),
   localparam int CNT_W = $clog2(PAGES + 1),
   localparam int REQ_DW = ((CNT_W + IDX_W + 7) / 8) * 8,
   localparam int RSP_DW = ((IDX_W + CNT_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request words.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_DW-1:0]              req_tdata,   // page_count, base_page
   input  logic                           req_tuser,   // mode
   // Response words.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_DW-1:0]              rsp_tdata,   // page_index, free_total
   output logic [ffpa_pkg::STATUS_W-1:0]  rsp_tuser,   // status
   // Managed size register.
   input  logic                           csr_we,
   input  logic [CNT_W-1:0]               csr_wdata
);

   localparam int PTR_W = CNT_W + 1;
   localparam int ST_W  = 4;

   localparam logic [ST_W-1:0] S_INIT    = 4'd0;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd1;
   localparam logic [ST_W-1:0] S_A_SCAN  = 4'd2;
   localparam logic [ST_W-1:0] S_A_CLR   = 4'd3;
   localparam logic [ST_W-1:0] S_A_REM   = 4'd4;
   localparam logic [ST_W-1:0] S_F_CHK   = 4'd5;
   localparam logic [ST_W-1:0] S_F_SET   = 4'd6;
   localparam logic [ST_W-1:0] S_F_TOPRD = 4'd7;
   localparam logic [ST_W-1:0] S_F_TOPCK = 4'd8;
   localparam logic [ST_W-1:0] S_F_TOPCL = 4'd9;
   localparam logic [ST_W-1:0] S_F_BSTRT = 4'd10;
   localparam logic [ST_W-1:0] S_F_BELOW = 4'd11;
   localparam logic [ST_W-1:0] S_F_BCLR  = 4'd12;
   localparam logic [ST_W-1:0] S_F_DONE  = 4'd13;
   localparam logic [ST_W-1:0] S_RESP    = 4'd14;

   localparam logic [PTR_W-1:0] PAGES_P = PTR_W'(PAGES);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(PAGES - 1);
   localparam logic [PTR_W-1:0] ONE_P   = PTR_W'(1);
   localparam logic [CNT_W-1:0] PAGES_C = CNT_W'(PAGES);
   localparam logic [CNT_W-1:0] RESET_M = CNT_W'((PAGES < 256) ? PAGES : 256);

   // Page store: free flags and block lengths, one port each way.
   logic             free_mem [PAGES];
   logic [CNT_W-1:0] len_mem  [PAGES];

   logic             free_rd_ff;
   logic [CNT_W-1:0] len_rd_ff;

   logic [ST_W-1:0]  state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0] managed_ff, managed_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [ffpa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_index_ff, res_index_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ffpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0] rsp_total_ff, rsp_total_in;

   logic             rd_issue;
   logic [PTR_W-1:0] rd_ptr;
   logic             free_we;
   logic [IDX_W-1:0] free_waddr;
   logic             free_wdata;
   logic             len_we;
   logic [IDX_W-1:0] len_waddr;
   logic [CNT_W-1:0] len_wdata;

   logic             req_accept;
   logic             req_mode;
   logic [CNT_W-1:0] req_count;
   logic [IDX_W-1:0] req_base;
   logic [PTR_W-1:0] req_top;
   logic [PTR_W-1:0] top_w;
   logic [PTR_W-1:0] base_p;
   logic [CNT_W-1:0] csr_sat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign req_count  = req_tdata[CNT_W-1:0];
   assign req_base   = req_tdata[CNT_W+IDX_W-1:CNT_W];
   assign req_top    = PTR_W'(req_base) + PTR_W'(req_count);
   assign base_p     = PTR_W'(base_ff);
   assign top_w      = base_p + PTR_W'(cnt_ff);
   assign csr_sat    = (csr_wdata > PAGES_C) ? PAGES_C : csr_wdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DW'({rsp_total_ff, rsp_index_ff});

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      free_rd_ff <= free_mem[rd_ptr[IDX_W-1:0]];
      len_rd_ff  <= len_mem[rd_ptr[IDX_W-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      managed_in    = managed_ff;
      free_count_in = free_count_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_total_in  = rsp_total_ff;
      rd_issue      = 1'b0;
      rd_ptr        = ptr_ff;
      free_we       = 1'b0;
      free_waddr    = ptr_ff[IDX_W-1:0];
      free_wdata    = 1'b0;
      len_we        = 1'b0;
      len_waddr     = ptr_ff[IDX_W-1:0];
      len_wdata     = '0;

      unique case (state_ff)
         S_INIT: begin
            free_we    = 1'b1;
            free_wdata = (ptr_ff < PTR_W'(managed_ff));
            len_we     = 1'b1;
            len_wdata  = (ptr_ff == '0) ? managed_ff : '0;
            ptr_in     = ptr_ff + ONE_P;
            if (ptr_ff == LAST_P) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               cnt_in  = req_count;
               base_in = req_base;
               ptr_in  = '0;
               if (req_mode == ffpa_pkg::MODE_ALLOC) begin
                  if (req_count == '0) begin
                     res_status_in = ffpa_pkg::ST_BAD;
                     res_index_in  = '0;
                     state_in      = S_RESP;
                  end else if (req_count > free_count_ff) begin
                     res_status_in = ffpa_pkg::ST_NOFIT;
                     res_index_in  = '0;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_A_SCAN;
                  end
               end else begin
                  if (req_count == '0 || req_top > PTR_W'(managed_ff)) begin
                     res_status_in = ffpa_pkg::ST_BAD;
                     res_index_in  = '0;
                     state_in      = S_RESP;
                  end else begin
                     ptr_in   = PTR_W'(req_base);
                     state_in = S_F_CHK;
                  end
               end
            end
         end
         S_A_SCAN: begin
            // Reads stream one address ahead of the fit check.
            rd_issue = (ptr_ff < PAGES_P);
            if (rd_issue) begin
               ptr_in = ptr_ff + ONE_P;
            end
            if (rd_valid_ff) begin
               if (free_rd_ff && len_rd_ff >= cnt_ff) begin
                  rd_issue = 1'b0;
                  ptr_in   = rd_addr_ff;
                  base_in  = rd_addr_ff[IDX_W-1:0];
                  len_in   = len_rd_ff;
                  state_in = S_A_CLR;
               end else if (rd_addr_ff == LAST_P) begin
                  res_status_in = ffpa_pkg::ST_NOFIT;
                  res_index_in  = '0;
                  state_in      = S_RESP;
               end
            end
         end
         S_A_CLR: begin
            free_we    = (ptr_ff < PAGES_P);
            free_wdata = 1'b0;
            if (ptr_ff == base_p) begin
               len_we    = 1'b1;
               len_waddr = base_ff;
               len_wdata = '0;
            end
            ptr_in = ptr_ff + ONE_P;
            if (ptr_ff == top_w - ONE_P) begin
               state_in = S_A_REM;
            end
         end
         S_A_REM: begin
            // The unused tail of the block becomes a block of its own.
            if (len_ff > cnt_ff && top_w < PAGES_P) begin
               len_we    = 1'b1;
               len_waddr = top_w[IDX_W-1:0];
               len_wdata = len_ff - cnt_ff;
            end
            free_count_in = free_count_ff - cnt_ff;
            res_status_in = ffpa_pkg::ST_OK;
            res_index_in  = base_ff;
            state_in      = S_RESP;
         end
         S_F_CHK: begin
            rd_issue = (ptr_ff != top_w);
            if (rd_issue) begin
               ptr_in = ptr_ff + ONE_P;
            end
            if (rd_valid_ff) begin
               if (free_rd_ff) begin
                  rd_issue      = 1'b0;
                  res_status_in = ffpa_pkg::ST_BAD;
                  res_index_in  = '0;
                  state_in      = S_RESP;
               end else if (rd_addr_ff == top_w - ONE_P) begin
                  ptr_in   = base_p;
                  state_in = S_F_SET;
               end
            end
         end
         S_F_SET: begin
            free_we    = 1'b1;
            free_wdata = 1'b1;
            len_we     = 1'b1;
            len_wdata  = (ptr_ff == base_p) ? cnt_ff : '0;
            len_in     = cnt_ff;
            ptr_in     = ptr_ff + ONE_P;
            if (ptr_ff == top_w - ONE_P) begin
               state_in = S_F_TOPRD;
            end
         end
         S_F_TOPRD: begin
            if (top_w < PAGES_P) begin
               rd_issue = 1'b1;
               rd_ptr   = top_w;
               state_in = S_F_TOPCK;
            end else begin
               state_in = S_F_BSTRT;
            end
         end
         S_F_TOPCK: begin
            if (free_rd_ff) begin
               len_in    = len_ff + len_rd_ff;
               len_we    = 1'b1;
               len_waddr = base_ff;
               len_wdata = len_ff + len_rd_ff;
               state_in  = S_F_TOPCL;
            end else begin
               state_in = S_F_BSTRT;
            end
         end
         S_F_TOPCL: begin
            len_we    = 1'b1;
            len_waddr = top_w[IDX_W-1:0];
            len_wdata = '0;
            state_in  = S_F_BSTRT;
         end
         S_F_BSTRT: begin
            if (base_ff != '0) begin
               ptr_in   = base_p - ONE_P;
               state_in = S_F_BELOW;
            end else begin
               state_in = S_F_DONE;
            end
         end
         S_F_BELOW: begin
            // Walk down to the head of the free block just below; the pointer
            // wraps past page zero, which stops further reads.
            rd_issue = !ptr_ff[PTR_W-1];
            if (rd_issue) begin
               ptr_in = ptr_ff - ONE_P;
            end
            if (rd_valid_ff) begin
               if (rd_addr_ff == base_p - ONE_P && !free_rd_ff) begin
                  rd_issue = 1'b0;
                  state_in = S_F_DONE;
               end else if (len_rd_ff != '0 || rd_addr_ff == '0) begin
                  rd_issue  = 1'b0;
                  len_we    = 1'b1;
                  len_waddr = rd_addr_ff[IDX_W-1:0];
                  len_wdata = len_rd_ff + len_ff;
                  state_in  = S_F_BCLR;
               end
            end
         end
         S_F_BCLR: begin
            len_we    = 1'b1;
            len_waddr = base_ff;
            len_wdata = '0;
            state_in  = S_F_DONE;
         end
         S_F_DONE: begin
            free_count_in = free_count_ff + cnt_ff;
            res_status_in = ffpa_pkg::ST_OK;
            res_index_in  = '0;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_total_in  = free_count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write of the managed size rebuilds the whole pool.
      if (csr_we) begin
         managed_in    = csr_sat;
         free_count_in = csr_sat;
         ptr_in        = '0;
         rd_issue      = 1'b0;
         state_in      = S_INIT;
      end
   end

   assign rd_valid_in = rd_issue;
   assign rd_addr_in  = rd_ptr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         ptr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         managed_ff    <= RESET_M;
         free_count_ff <= RESET_M;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         rd_valid_ff   <= rd_valid_in;
         managed_ff    <= managed_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      len_ff        <= len_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // A failed request never reports a page.
   a_fail_index_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ffpa_pkg::ST_OK |-> rsp_index_ff == '0)
      else $error("failed response carries a nonzero page index");

   // The free total never exceeds the managed pool.
   a_free_bounded : assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= managed_ff)
      else $error("free page total exceeds managed size");

   // Only one request is worked on at a time.
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while another is in progress");

   // No request is taken during the clearing pass.
   a_no_req_in_init : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !req_tready)
      else $error("request taken during pool clearing pass");

endmodule

### sim/first_fit_page_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_test: self-checking bench for the page allocator
// Drives allocate and free request words, predicts every response word from
// a shadow copy of the page pool, and compares status, page index and free
// total. Directed cases cover bad requests, fragmentation, both merge paths
// and the pool size extremes; random traffic then runs mostly well-formed
// allocate/free pairs over several pool sizes with varying back-pressure.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_test;

   localparam int PAGES     = 256;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;
   localparam int MAX_CYCLES = 1500000;
   localparam int DRAIN_CYCLES = 2 * PAGES + 8;

   typedef struct packed {
      logic [ffpa_pkg::STATUS_W-1:0] status;
      logic [7:0]                    page_index;
      logic [8:0]                    free_total;
   } page_resp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_W-1:0]              req_tdata = '0;     // page_count, base_page
   logic                          req_tuser = ffpa_pkg::MODE_ALLOC; // mode
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [RSP_W-1:0]              rsp_tdata;          // page_index, free_total
   logic [ffpa_pkg::STATUS_W-1:0] rsp_tuser;          // status
   logic                          csr_we = 1'b0;
   logic [8:0]                    csr_wdata = '0;

   // Shadow copy of the page pool.
   bit         pool_free [PAGES];
   int         run_len [PAGES];
   int         pages_free;
   int         pool_size;

   page_resp_type pending_resp [$];
   int         live_base [$];
   int         live_cnt [$];
   int         fail_cnt = 0;
   int         cycle_cnt = 0;
   int         send_idle_pct = 9;
   int         recv_idle_pct = 52;

   first_fit_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int pool_limit();
      return (pool_size > PAGES) ? PAGES : pool_size;
   endfunction

   function automatic void pool_reinit(input int size);
      int i;
      int m;
      pool_size = size;
      m = pool_limit();
      for (i = 0; i < PAGES; i++) begin
         pool_free[i] = (i < m);
         run_len[i] = 0;
      end
      run_len[0] = m;
      pages_free = m;
   endfunction

   function automatic void alloc_pages(input int cnt, inout page_resp_type r);
      int  i;
      int  k;
      int  len;
      bit  found;
      found = 1'b0;
      r.status = ffpa_pkg::ST_NOFIT;
      for (i = 0; i < PAGES && !found; i++) begin
         len = run_len[i];
         if (pool_free[i] && len >= cnt) begin
            for (k = 0; k < cnt && i + k < PAGES; k++)
               pool_free[i + k] = 1'b0;
            run_len[i] = 0;
            // Whatever is left of the block keeps its head right above the cut.
            if (len > cnt && i + cnt < PAGES)
               run_len[i + cnt] = len - cnt;
            pages_free -= cnt;
            r.status = ffpa_pkg::ST_OK;
            r.page_index = i[7:0];
            found = 1'b1;
         end
      end
   endfunction

   function automatic logic [ffpa_pkg::STATUS_W-1:0] free_pages(input int base,
                                                                input int cnt);
      int k;
      int h;
      if (cnt == 0 || base + cnt > pool_limit())
         return ffpa_pkg::ST_BAD;
      for (k = 0; k < cnt; k++)
         if (pool_free[base + k])
            return ffpa_pkg::ST_BAD;
      for (k = 0; k < cnt; k++) begin
         pool_free[base + k] = 1'b1;
         run_len[base + k] = 0;
      end
      run_len[base] = cnt;
      if (base + cnt < PAGES && pool_free[base + cnt]) begin
         run_len[base] += run_len[base + cnt];
         run_len[base + cnt] = 0;
      end
      // The block below is found by walking down to its head.
      if (base > 0 && pool_free[base - 1]) begin
         h = base - 1;
         while (h > 0 && run_len[h] == 0)
            h--;
         run_len[h] += run_len[base];
         run_len[base] = 0;
      end
      pages_free += cnt;
      return ffpa_pkg::ST_OK;
   endfunction

   function automatic page_resp_type predict_response(input logic mode, input int cnt,
                                                      input int base);
      page_resp_type r;
      r = '0;
      if (mode == ffpa_pkg::MODE_ALLOC) begin
         if (cnt == 0)
            r.status = ffpa_pkg::ST_BAD;
         else if (cnt > pages_free)
            r.status = ffpa_pkg::ST_NOFIT;
         else
            alloc_pages(cnt, r);
      end else begin
         r.status = free_pages(base, cnt);
      end
      if (r.status != ffpa_pkg::ST_OK)
         r.page_index = '0;
      r.free_total = pages_free[8:0];
      return r;
   endfunction

   // Called right after a falling edge; returns right after a falling edge.
   task automatic send_request(input logic mode, input int cnt, input int base,
                               output page_resp_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, base[7:0], cnt[8:0]};
      do
         @(posedge clock);
      while (!req_tready);
      r = predict_response(mode, cnt, base);
      pending_resp.push_back(r);
      if (mode == ffpa_pkg::MODE_ALLOC && r.status == ffpa_pkg::ST_OK) begin
         live_base.push_back(r.page_index);
         live_cnt.push_back(cnt);
      end
      @(negedge clock);
   endtask

   task automatic send_word(input logic mode, input int cnt, input int base);
      page_resp_type r;
      send_request(mode, cnt, base, r);
   endtask

   task automatic wait_all_responses();
      req_tvalid <= 1'b0;
      while (pending_resp.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_pool_size(input int size);
      wait_all_responses();
      csr_we    <= 1'b1;
      csr_wdata <= size[8:0];
      @(posedge clock);
      pool_reinit(size & 'h1FF);
      live_base.delete();
      live_cnt.delete();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      page_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            $error("response word with no request outstanding");
            fail_cnt++;
         end else begin
            want = pending_resp.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               fail_cnt++;
            end
            if (rsp_tdata[7:0] !== want.page_index) begin
               $error("page_index: expected %0d, actual %0d", want.page_index,
                      rsp_tdata[7:0]);
               fail_cnt++;
            end
            if (rsp_tdata[16:8] !== want.free_total) begin
               $error("free_total: expected %0d, actual %0d", want.free_total,
                      rsp_tdata[16:8]);
               fail_cnt++;
            end
         end
      end
   end

   task automatic test_bad_requests();
      send_word(ffpa_pkg::MODE_ALLOC, 0, 0);      // zero count
      send_word(ffpa_pkg::MODE_FREE, 0, 0);
      send_word(ffpa_pkg::MODE_ALLOC, 256, 255);  // whole pool, base is ignored
      send_word(ffpa_pkg::MODE_ALLOC, 1, 0);      // more than the free total
      send_word(ffpa_pkg::MODE_FREE, 57, 200);    // runs past the pool
      send_word(ffpa_pkg::MODE_FREE, 1, 255);
      send_word(ffpa_pkg::MODE_FREE, 1, 255);     // page is already free
   endtask

   task automatic test_merge_paths();
      send_word(ffpa_pkg::MODE_FREE, 100, 0);
      send_word(ffpa_pkg::MODE_FREE, 1, 128);
      send_word(ffpa_pkg::MODE_ALLOC, 101, 0);    // enough pages, but split up
      send_word(ffpa_pkg::MODE_FREE, 10, 100);    // merges with the block below
      send_word(ffpa_pkg::MODE_FREE, 1, 127);     // merges with the block above
      send_word(ffpa_pkg::MODE_FREE, 17, 110);    // merges on both sides
      send_word(ffpa_pkg::MODE_FREE, 126, 129);
      send_word(ffpa_pkg::MODE_ALLOC, 3, 170);
   endtask

   task automatic test_pool_size_extremes();
      write_pool_size(1);
      send_word(ffpa_pkg::MODE_ALLOC, 1, 0);
      send_word(ffpa_pkg::MODE_FREE, 1, 1);
      send_word(ffpa_pkg::MODE_FREE, 1, 0);
      write_pool_size(0);
      send_word(ffpa_pkg::MODE_ALLOC, 1, 0);
      send_word(ffpa_pkg::MODE_FREE, 1, 0);
      // Sizes beyond the pool saturate to the full pool.
      write_pool_size(511);
      send_word(ffpa_pkg::MODE_ALLOC, 256, 0);
   endtask

   task automatic random_request();
      int  m;
      int  pick;
      int  j;
      int  b;
      int  c;
      int  off;
      int  len;
      int  cap;
      page_resp_type r;
      m = pool_limit();
      pick = $urandom_range(99);
      if (pick < 85 && pick >= 45 && live_base.size() != 0) begin
         j = $urandom_range(live_base.size() - 1);
         b = live_base[j];
         c = live_cnt[j];
         off = 0;
         len = c;
         if ($urandom_range(99) < 40) begin
            off = $urandom_range(c - 1);
            len = $urandom_range(c - off, 1);
         end
         live_base.delete(j);
         live_cnt.delete(j);
         if (off > 0) begin
            live_base.push_back(b);
            live_cnt.push_back(off);
         end
         if (off + len < c) begin
            live_base.push_back(b + off + len);
            live_cnt.push_back(c - off - len);
         end
         send_request(ffpa_pkg::MODE_FREE, len, b + off, r);
      end else if (pick < 85) begin
         cap = (m < 16) ? m : 16;
         if ($urandom_range(99) < 15)
            cap = m;
         if (cap < 1)
            cap = 1;
         send_request(ffpa_pkg::MODE_ALLOC, $urandom_range(cap, 1),
                      $urandom_range(255), r);
      end else begin
         send_request(logic'($urandom_range(1)), $urandom_range(256),
                      $urandom_range(255), r);
      end
   endtask

   task automatic test_random_traffic();
      int sizes [8];
      int ph;
      int n;
      sizes = '{256, 1, 2, 37, 255, 128, 256, 200};
      for (ph = 0; ph < 8; ph++) begin
         write_pool_size(sizes[ph]);
         if (ph < 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 52;
         end else if (ph < 6) begin
            send_idle_pct = 52;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < 62; n++)
            random_request();
      end
   endtask

   initial begin
      pool_reinit(256);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_bad_requests();
      test_merge_paths();
      test_pool_size_extremes();
      test_random_traffic();
      wait_all_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
